/* rtl/dslope_pkg.sv */
package dslope_pkg;

  // Default elevation sample width
  localparam int ELEV_BITS_DEF = 24;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_Y = 2'd1;
  localparam logic [31:0] RECIP_RESET = 32'd2097152;

  // Boundary codes
  localparam logic [3:0] BND_INTERIOR = 4'd0;
  localparam logic [3:0] BND_BOTTOM   = 4'd1;
  localparam logic [3:0] BND_RIGHT    = 4'd2;
  localparam logic [3:0] BND_TOP      = 4'd3;
  localparam logic [3:0] BND_LEFT     = 4'd4;
  localparam logic [3:0] BND_BL       = 4'd5;
  localparam logic [3:0] BND_BR       = 4'd6;
  localparam logic [3:0] BND_TR       = 4'd7;
  localparam logic [3:0] BND_TL       = 4'd8;

  // Bit positions in the neighbor presence mask
  localparam int NB_BOTTOM = 0;
  localparam int NB_BL     = 1;
  localparam int NB_BR     = 2;
  localparam int NB_LEFT   = 3;
  localparam int NB_RIGHT  = 4;
  localparam int NB_TOP    = 5;
  localparam int NB_TL     = 6;
  localparam int NB_TR     = 7;

  // Pipeline shape: seven arithmetic stages, then two root bits per stage
  localparam int NSQ = 16;
  localparam int NST = 7 + NSQ;

  // Square root remainder width
  localparam int REM_W = 34;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [31:0]      root;
    logic [63:0]      rad;
  } sq_state_t;

  // Present neighbors per boundary code; unknown codes keep none
  function automatic logic [7:0] present_mask(input logic [3:0] code);
    logic [7:0] m;
    case (code)
      BND_INTERIOR: m = 8'hFF;
      BND_BOTTOM:   m = 8'hF8;
      BND_RIGHT:    m = 8'h6B;
      BND_TOP:      m = 8'h1F;
      BND_LEFT:     m = 8'hB5;
      BND_BL:       m = 8'hB0;
      BND_BR:       m = 8'h68;
      BND_TR:       m = 8'h0B;
      BND_TL:       m = 8'h15;
      default:      m = 8'h00;
    endcase
    return m;
  endfunction

  // One restoring square root step: bring down two radicand bits, try a root bit
  function automatic sq_state_t sqrt_step(input sq_state_t s);
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    sq_state_t        o;
    rem_sh = {s.rem, s.rad[63:62]};
    trial  = {2'b00, s.root, 2'b01};
    if (rem_sh >= trial) begin
      o.rem  = REM_W'(rem_sh - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = REM_W'(rem_sh);
      o.root = {s.root[30:0], 1'b0};
    end
    o.rad = {s.rad[61:0], 2'b00};
    return o;
  endfunction

endpackage

/* rtl/dem_slope_3x3.sv */
// Slope of one elevation cell from its 3x3 window (Horn weighting).
// Input channel (in_valid/in_ready): the center cell, its eight neighbors
// and a boundary code; neighbors the code marks absent take the center value.
// Output channel (out_valid/out_ready): slope in unsigned Q16.16 and a flag
// set when the slope clips at all ones.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 writes recip_x,
// index 1 writes recip_y; other indexes are dropped. Write only while idle.
// Pipeline: seven arithmetic stages (sums, abs, partial products, combine,
// square partials, square assembly, sum of squares) and sixteen square root
// stages that resolve two root bits each.
// Throughput: one beat per cycle while the receiver does not stall.
// Reset (rst_n low, synchronous): all stage valids clear and both
// reciprocals return to 2097152 (cell size one).
// When the receiver stalls, the output stage holds, stages behind it close
// their bubbles, and in_ready drops only once every stage holds an item.
module dem_slope_3x3 import dslope_pkg::*; #(
  parameter int ELEVATION_BITS = ELEV_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_center,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_bottom,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_bottom_left,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_bottom_right,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_left,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_right,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_top,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_top_left,
  input  logic signed [ELEVATION_BITS-1:0] in_elev_top_right,
  input  logic        [3:0]                in_boundary_code,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic        [31:0]               out_slope,
  output logic                             out_saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic        [CFG_IDX_W-1:0]      cfg_index,
  input  logic        [31:0]               cfg_data
);

  localparam int SUM_W  = ELEVATION_BITS + 2;
  localparam int DIFF_W = ELEVATION_BITS + 3;
  localparam int ABS_W  = ELEVATION_BITS + 2;
  localparam int HI_W   = (ABS_W > 32) ? (ABS_W - 32) : 1;
  localparam int PAD_W  = 32 + HI_W;
  localparam int PHI_W  = HI_W + 32;
  localparam int A_W    = 64 + HI_W;

  localparam int ST_SUM   = 0;
  localparam int ST_ABS   = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_WIDE  = 3;
  localparam int ST_PP    = 4;
  localparam int ST_SQ    = 5;
  localparam int ST_RAD   = 6;
  localparam int ST_ROOT0 = 7;

  // Configuration registers
  logic [31:0] recip_x_r;
  logic [31:0] recip_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_x_r <= RECIP_RESET;
      recip_y_r <= RECIP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RECIP_X: recip_x_r <= cfg_data;
        CFG_RECIP_Y: recip_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance; bubbles close under a stall
  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;
  logic [NST-1:0] v_in;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign v_in     = {v_r[NST-2:0], in_valid};
  assign in_ready = adv[ST_SUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (adv & v_in) | (~adv & v_r);
    end
  end

  // Stage 0: substitute absent neighbors, form weighted row and column sums
  logic [7:0] pres;
  logic signed [ELEVATION_BITS-1:0] e_b, e_bl, e_br, e_l, e_r, e_t, e_tl, e_tr;
  logic signed [SUM_W-1:0] right_nxt, left_nxt, upper_nxt, lower_nxt;
  logic signed [SUM_W-1:0] right_r, left_r, upper_r, lower_r;

  assign pres = present_mask(in_boundary_code);
  assign e_b  = pres[NB_BOTTOM] ? in_elev_bottom       : in_elev_center;
  assign e_bl = pres[NB_BL]     ? in_elev_bottom_left  : in_elev_center;
  assign e_br = pres[NB_BR]     ? in_elev_bottom_right : in_elev_center;
  assign e_l  = pres[NB_LEFT]   ? in_elev_left         : in_elev_center;
  assign e_r  = pres[NB_RIGHT]  ? in_elev_right        : in_elev_center;
  assign e_t  = pres[NB_TOP]    ? in_elev_top          : in_elev_center;
  assign e_tl = pres[NB_TL]     ? in_elev_top_left     : in_elev_center;
  assign e_tr = pres[NB_TR]     ? in_elev_top_right    : in_elev_center;

  assign right_nxt = SUM_W'(e_tr) + (SUM_W'(e_r) <<< 1) + SUM_W'(e_br);
  assign left_nxt  = SUM_W'(e_tl) + (SUM_W'(e_l) <<< 1) + SUM_W'(e_bl);
  assign upper_nxt = SUM_W'(e_tl) + (SUM_W'(e_t) <<< 1) + SUM_W'(e_tr);
  assign lower_nxt = SUM_W'(e_bl) + (SUM_W'(e_b) <<< 1) + SUM_W'(e_br);

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      right_r <= right_nxt;
      left_r  <= left_nxt;
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
    end
  end

  // Stage 1: differences and their magnitudes
  logic signed [DIFF_W-1:0] dx, dy;
  logic [ABS_W-1:0] absx_nxt, absy_nxt, absx_r, absy_r;

  assign dx       = DIFF_W'(right_r) - DIFF_W'(left_r);
  assign dy       = DIFF_W'(upper_r) - DIFF_W'(lower_r);
  assign absx_nxt = dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
  assign absy_nxt = dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);

  always_ff @(posedge clk) begin
    if (adv[ST_ABS]) begin
      absx_r <= absx_nxt;
      absy_r <= absy_nxt;
    end
  end

  // Stage 2: partial products of magnitude and reciprocal
  logic [PAD_W-1:0] absx_pad, absy_pad;
  logic [63:0]      plox_r, ploy_r;
  logic [PHI_W-1:0] phix_r, phiy_r;

  assign absx_pad = PAD_W'(absx_r);
  assign absy_pad = PAD_W'(absy_r);

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      plox_r <= 64'(absx_pad[31:0]) * 64'(recip_x_r);
      ploy_r <= 64'(absy_pad[31:0]) * 64'(recip_y_r);
      phix_r <= PHI_W'(absx_pad[PAD_W-1:32]) * PHI_W'(recip_x_r);
      phiy_r <= PHI_W'(absy_pad[PAD_W-1:32]) * PHI_W'(recip_y_r);
    end
  end

  // Stage 3: combine partials; a term at 2^40 or above saturates
  logic [A_W-1:0] ax, ay;
  logic [39:0]    ax_r, ay_r;
  logic           sat3_r;

  assign ax = A_W'(plox_r) + {phix_r, 32'b0};
  assign ay = A_W'(ploy_r) + {phiy_r, 32'b0};

  always_ff @(posedge clk) begin
    if (adv[ST_WIDE]) begin
      ax_r   <= ax[39:0];
      ay_r   <= ay[39:0];
      sat3_r <= (|ax[A_W-1:40]) | (|ay[A_W-1:40]);
    end
  end

  // Stage 4: 20-bit partial products of the squares
  logic [39:0] hhx_r, hlx_r, llx_r, hhy_r, hly_r, lly_r;
  logic        sat4_r;

  always_ff @(posedge clk) begin
    if (adv[ST_PP]) begin
      hhx_r  <= 40'(ax_r[39:20]) * 40'(ax_r[39:20]);
      hlx_r  <= 40'(ax_r[39:20]) * 40'(ax_r[19:0]);
      llx_r  <= 40'(ax_r[19:0])  * 40'(ax_r[19:0]);
      hhy_r  <= 40'(ay_r[39:20]) * 40'(ay_r[39:20]);
      hly_r  <= 40'(ay_r[39:20]) * 40'(ay_r[19:0]);
      lly_r  <= 40'(ay_r[19:0])  * 40'(ay_r[19:0]);
      sat4_r <= sat3_r;
    end
  end

  // Stage 5: assemble each square
  logic [79:0] sqx_r, sqy_r;
  logic        sat5_r;

  always_ff @(posedge clk) begin
    if (adv[ST_SQ]) begin
      sqx_r  <= (80'(hhx_r) << 40) + (80'(hlx_r) << 21) + 80'(llx_r);
      sqy_r  <= (80'(hhy_r) << 40) + (80'(hly_r) << 21) + 80'(lly_r);
      sat5_r <= sat4_r;
    end
  end

  // Stage 6: sum of squares, drop 16 fraction bits, check the top
  logic [80:0] sum_sq;
  logic [63:0] rad6_r;
  logic        sat6_r;

  assign sum_sq = 81'(sqx_r) + 81'(sqy_r);

  always_ff @(posedge clk) begin
    if (adv[ST_RAD]) begin
      rad6_r <= sum_sq[79:16];
      sat6_r <= sat5_r | sum_sq[80];
    end
  end

  // Stages 7 to 22: integer square root, two root bits per stage
  sq_state_t sq_r     [NSQ];
  logic      sq_sat_r [NSQ];

  for (genvar j = 0; j < NSQ; j++) begin : g_root
    sq_state_t src;
    logic      src_sat;
    if (j == 0) begin : g_first
      assign src     = '{rem: '0, root: '0, rad: rad6_r};
      assign src_sat = sat6_r;
    end else begin : g_next
      assign src     = sq_r[j-1];
      assign src_sat = sq_sat_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv[ST_ROOT0+j]) begin
        sq_r[j]     <= sqrt_step(sqrt_step(src));
        sq_sat_r[j] <= src_sat;
      end
    end
  end

  // Output: the last root stage is the output register
  assign out_valid     = v_r[NST-1];
  assign out_saturated = sq_sat_r[NSQ-1];
  assign out_slope     = sq_sat_r[NSQ-1] ? '1 : sq_r[NSQ-1].root;

  // Checks
  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_slope == '1)
    else $error("saturated result without clipped slope");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[ST_SUM] |-> in_ready)
    else $error("input stalled with an empty first stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[ST_SUM])
    else $error("accepted beat missing from first stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

/* test/tb_top.sv */
module tb_top;
  import dslope_pkg::*;

  localparam int EW          = ELEV_BITS_DEF;
  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASE_CELLS = 176;
  localparam int TAIL_CELLS  = 120;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_PAD   = 40;

  // Indexes past the two reciprocals; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef logic signed [EW-1:0] elev_t;

  localparam elev_t ELEV_MAX = elev_t'((1 << (EW - 1)) - 1);
  localparam elev_t ELEV_MIN = elev_t'(-(1 << (EW - 1)));

  typedef struct {
    elev_t      center;
    elev_t      bottom;
    elev_t      bottom_left;
    elev_t      bottom_right;
    elev_t      left;
    elev_t      right;
    elev_t      top;
    elev_t      top_left;
    elev_t      top_right;
    logic [3:0] code;
  } cell_win_t;

  typedef struct packed {
    logic [31:0] slope;
    logic        sat;
  } slope_res_t;

  typedef enum logic {STEP_CELL, STEP_REG_WRITE} plan_kind_t;

  typedef struct {
    plan_kind_t           kind;
    cell_win_t            win;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
  } plan_step_t;

  // How terrain is shaped for a random window
  typedef enum logic [2:0] {
    SPREAD_FULL, SPREAD_FINE, SPREAD_HILL, SPREAD_RIDGE, SPREAD_EXTREME
  } spread_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  elev_t                in_elev_center = '0;
  elev_t                in_elev_bottom = '0;
  elev_t                in_elev_bottom_left = '0;
  elev_t                in_elev_bottom_right = '0;
  elev_t                in_elev_left = '0;
  elev_t                in_elev_right = '0;
  elev_t                in_elev_top = '0;
  elev_t                in_elev_top_left = '0;
  elev_t                in_elev_top_right = '0;
  logic [3:0]           in_boundary_code = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          out_slope;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  plan_step_t cell_plan[$];
  slope_res_t pending_slopes[$];
  cell_win_t  cur_cell;
  logic [31:0] recip_x_sh = RECIP_RESET;
  logic [31:0] recip_y_sh = RECIP_RESET;
  int          cells_sent = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;
  logic        tail_run = 1'b0;
  logic        long_hold = 1'b0;

  dem_slope_3x3 dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_elev_center      (in_elev_center),
    .in_elev_bottom      (in_elev_bottom),
    .in_elev_bottom_left (in_elev_bottom_left),
    .in_elev_bottom_right(in_elev_bottom_right),
    .in_elev_left        (in_elev_left),
    .in_elev_right       (in_elev_right),
    .in_elev_top         (in_elev_top),
    .in_elev_top_left    (in_elev_top_left),
    .in_elev_top_right   (in_elev_top_right),
    .in_boundary_code    (in_boundary_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_slope           (out_slope),
    .out_saturated       (out_saturated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Integer square root, one root bit per pass from the top
  function automatic logic [31:0] int_sqrt(logic [63:0] v);
    logic [31:0] root;
    logic [63:0] trial;
    int          i;
    root = '0;
    for (i = 31; i >= 0; i--) begin
      trial = {32'd0, root | (32'd1 << i)};
      if (trial * trial <= v) begin
        root = root | (32'd1 << i);
      end
    end
    return root;
  endfunction

  // Horn gradient magnitude of one window in Q16.16
  function automatic slope_res_t horn_slope(cell_win_t w, logic [31:0] rx, logic [31:0] ry);
    logic        no_bot, no_top, no_lft, no_rgt;
    int          c, b, bl, br, l, r, t, tl, tr, dx, dy;
    logic [31:0] mag_x, mag_y;
    logic [63:0] ax, ay;
    logic [127:0] sq;
    slope_res_t  res;
    no_bot = 1'b0;
    no_top = 1'b0;
    no_lft = 1'b0;
    no_rgt = 1'b0;
    // Mark the missing row and column of the window
    case (w.code)
      BND_INTERIOR: ;
      BND_BOTTOM:   no_bot = 1'b1;
      BND_RIGHT:    no_rgt = 1'b1;
      BND_TOP:      no_top = 1'b1;
      BND_LEFT:     no_lft = 1'b1;
      BND_BL: begin
        no_bot = 1'b1;
        no_lft = 1'b1;
      end
      BND_BR: begin
        no_bot = 1'b1;
        no_rgt = 1'b1;
      end
      BND_TR: begin
        no_top = 1'b1;
        no_rgt = 1'b1;
      end
      BND_TL: begin
        no_top = 1'b1;
        no_lft = 1'b1;
      end
      default: begin
        no_bot = 1'b1;
        no_top = 1'b1;
        no_lft = 1'b1;
        no_rgt = 1'b1;
      end
    endcase
    // Replace missing neighbors with the center
    c  = w.center;
    b  = no_bot ? c : int'(w.bottom);
    bl = (no_bot || no_lft) ? c : int'(w.bottom_left);
    br = (no_bot || no_rgt) ? c : int'(w.bottom_right);
    l  = no_lft ? c : int'(w.left);
    r  = no_rgt ? c : int'(w.right);
    t  = no_top ? c : int'(w.top);
    tl = (no_top || no_lft) ? c : int'(w.top_left);
    tr = (no_top || no_rgt) ? c : int'(w.top_right);
    dx = (tr + 2 * r + br) - (tl + 2 * l + bl);
    dy = (tl + 2 * t + tr) - (bl + 2 * b + br);
    mag_x = (dx < 0) ? -dx : dx;
    mag_y = (dy < 0) ? -dy : dy;
    ax = {32'd0, mag_x} * {32'd0, rx};
    ay = {32'd0, mag_y} * {32'd0, ry};
    sq = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    // Clip once the root no longer fits 32 bits
    if (sq[127:80] != '0) begin
      res.slope = '1;
      res.sat   = 1'b1;
    end else begin
      res.slope = int_sqrt(sq[79:16]);
      res.sat   = 1'b0;
    end
    return res;
  endfunction

  function automatic cell_win_t flat_cell(elev_t v, logic [3:0] code);
    cell_win_t w;
    w.center       = v;
    w.bottom       = v;
    w.bottom_left  = v;
    w.bottom_right = v;
    w.left         = v;
    w.right        = v;
    w.top          = v;
    w.top_left     = v;
    w.top_right    = v;
    w.code         = code;
    return w;
  endfunction

  function automatic elev_t pick_elev(spread_t spread, int base);
    int span;
    case (spread)
      SPREAD_FULL: return elev_t'($urandom);
      SPREAD_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return ELEV_MAX;
          1:       return ELEV_MIN;
          2:       return elev_t'(0);
          3:       return elev_t'(-1);
          default: return elev_t'(1);
        endcase
      end
      SPREAD_FINE: span = 15;
      SPREAD_HILL: span = 255;
      default:     span = 4095;
    endcase
    return elev_t'(base + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic cell_win_t random_cell(logic [3:0] code);
    cell_win_t w;
    spread_t   spread;
    int        base;
    spread = spread_t'($urandom_range(0, 4));
    base   = int'($urandom_range(0, 1 << (EW - 1))) - (1 << (EW - 2));
    w.center       = pick_elev(spread, base);
    w.bottom       = pick_elev(spread, base);
    w.bottom_left  = pick_elev(spread, base);
    w.bottom_right = pick_elev(spread, base);
    w.left         = pick_elev(spread, base);
    w.right        = pick_elev(spread, base);
    w.top          = pick_elev(spread, base);
    w.top_left     = pick_elev(spread, base);
    w.top_right    = pick_elev(spread, base);
    w.code         = code;
    return w;
  endfunction

  function automatic logic [3:0] random_code();
    if ($urandom_range(0, 7) == 0) begin
      return 4'($urandom_range(9, 15));
    end
    return 4'($urandom_range(0, 8));
  endfunction

  task automatic add_cell(cell_win_t w);
    plan_step_t s;
    s.kind    = STEP_CELL;
    s.win     = w;
    s.reg_idx = '0;
    s.reg_val = '0;
    cell_plan.push_back(s);
  endtask

  task automatic add_reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    plan_step_t s;
    s.kind    = STEP_REG_WRITE;
    s.win     = flat_cell(elev_t'(0), BND_INTERIOR);
    s.reg_idx = idx;
    s.reg_val = val;
    cell_plan.push_back(s);
  endtask

  task automatic add_random_cells(int n);
    int i;
    for (i = 0; i < n; i++) begin
      add_cell(random_cell(random_code()));
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
  endtask

  // Build the whole plan: directed windows at reset reciprocals, then phases
  initial begin
    cell_win_t w;
    int        k;
    add_cell(flat_cell(elev_t'(0), BND_INTERIOR));
    add_cell(flat_cell(ELEV_MAX, BND_INTERIOR));
    add_cell(flat_cell(ELEV_MIN, BND_INTERIOR));
    // One unit step to the right: a quarter in Q16.16
    w = flat_cell(elev_t'(0), BND_INTERIOR);
    w.right = elev_t'(1);
    add_cell(w);
    // Steepest east-west and north-south walls
    w = flat_cell(elev_t'(0), BND_INTERIOR);
    w.top_right = ELEV_MAX;
    w.right = ELEV_MAX;
    w.bottom_right = ELEV_MAX;
    w.top_left = ELEV_MIN;
    w.left = ELEV_MIN;
    w.bottom_left = ELEV_MIN;
    add_cell(w);
    w = flat_cell(elev_t'(0), BND_INTERIOR);
    w.top_left = ELEV_MAX;
    w.top = ELEV_MAX;
    w.top_right = ELEV_MAX;
    w.bottom_left = ELEV_MIN;
    w.bottom = ELEV_MIN;
    w.bottom_right = ELEV_MIN;
    add_cell(w);
    // Checkerboard of the extremes
    w = flat_cell(ELEV_MAX, BND_INTERIOR);
    w.top = ELEV_MIN;
    w.left = ELEV_MIN;
    w.right = ELEV_MIN;
    w.bottom = ELEV_MIN;
    add_cell(w);
    // Deep pit on a corner: absent neighbors must take the center
    w = flat_cell(ELEV_MAX, BND_TR);
    w.center = ELEV_MIN;
    add_cell(w);
    // Every boundary code, unknown ones included
    for (k = 0; k < 16; k++) begin
      add_cell(random_cell(4'(k)));
    end

    add_reg_write(CFG_RECIP_X, 32'd0);
    add_reg_write(CFG_RECIP_Y, 32'd0);
    add_random_cells(PHASE_CELLS);
    add_reg_write(CFG_RECIP_X, 32'd1);
    add_reg_write(CFG_RECIP_Y, 32'd1);
    add_random_cells(PHASE_CELLS);
    add_reg_write(CFG_RECIP_X, '1);
    add_reg_write(CFG_RECIP_Y, '1);
    add_random_cells(PHASE_CELLS);
    add_reg_write(CFG_RECIP_X, $urandom_range(2048, 2097152));
    add_reg_write(CFG_RECIP_Y, $urandom_range(2048, 2097152));
    add_reg_write(CFG_SPARE_A, $urandom);
    add_reg_write(CFG_SPARE_B, $urandom);
    add_random_cells(PHASE_CELLS);
    add_reg_write(CFG_RECIP_X, 32'd0);
    add_reg_write(CFG_RECIP_Y, $urandom);
    add_random_cells(PHASE_CELLS);
    add_reg_write(CFG_RECIP_X, $urandom);
    add_reg_write(CFG_RECIP_Y, 32'd1);
    add_random_cells(PHASE_CELLS);
    add_reg_write(CFG_RECIP_X, RECIP_RESET);
    add_reg_write(CFG_RECIP_Y, $urandom_range(1 << 16, 1 << 24));
    add_random_cells(PHASE_CELLS);
  end

  // Driver: offer cells and register writes from the plan
  always @(posedge clk) begin
    logic nv;
    logic ncv;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      cfg_valid  <= 1'b0;
      recip_x_sh = RECIP_RESET;
      recip_y_sh = RECIP_RESET;
      gap_left   = 0;
    end else begin
      // Predict each accepted cell beat with the current reciprocals
      if (in_valid && in_ready) begin
        pending_slopes.push_back(horn_slope(cur_cell, recip_x_sh, recip_y_sh));
        cells_sent++;
        if (!tail_run && !cycle_cnt[7] && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 15);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RECIP_X: recip_x_sh = cfg_data;
          CFG_RECIP_Y: recip_y_sh = cfg_data;
          default: ;
        endcase
      end
      nv  = in_valid && !in_ready;
      ncv = cfg_valid && !cfg_ready;
      // Advance only when nothing is waiting on a handshake
      if (!nv && !ncv) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cell_plan.size() != 0) begin
          if (cell_plan[0].kind == STEP_CELL) begin
            cur_cell = cell_plan[0].win;
            in_elev_center       <= cur_cell.center;
            in_elev_bottom       <= cur_cell.bottom;
            in_elev_bottom_left  <= cur_cell.bottom_left;
            in_elev_bottom_right <= cur_cell.bottom_right;
            in_elev_left         <= cur_cell.left;
            in_elev_right        <= cur_cell.right;
            in_elev_top          <= cur_cell.top;
            in_elev_top_left     <= cur_cell.top_left;
            in_elev_top_right    <= cur_cell.top_right;
            in_boundary_code     <= cur_cell.code;
            nv = 1'b1;
            void'(cell_plan.pop_front());
          end else if (pending_slopes.size() == 0) begin
            // Register writes wait until the pipeline has drained
            cfg_index <= cell_plan[0].reg_idx;
            cfg_data  <= cell_plan[0].reg_val;
            ncv = 1'b1;
            void'(cell_plan.pop_front());
          end
        end
      end
      in_valid  <= nv;
      cfg_valid <= ncv;
      tail_run  <= (cell_plan.size() < TAIL_CELLS);
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    slope_res_t exp_res;
    logic       nr;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_slopes.size() == 0) begin
          note_mismatch($sformatf("unexpected result slope %h saturated %b",
                                  out_slope, out_saturated));
        end else begin
          exp_res = pending_slopes.pop_front();
          if (out_slope !== exp_res.slope) begin
            note_mismatch($sformatf("slope expected %h, got %h", exp_res.slope, out_slope));
          end
          if (out_saturated !== exp_res.sat) begin
            note_mismatch($sformatf("saturated expected %b, got %b",
                                    exp_res.sat, out_saturated));
          end
        end
      end
      // Stall in random bursts, except in quiet stretches and the tail
      if (stall_left != 0) begin
        stall_left--;
        nr = 1'b0;
      end else if (!tail_run && !cycle_cnt[8] && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_ready <= nr && !long_hold;
    end
  end

  // Hold the result side off long enough to back up the whole pipeline
  initial begin
    wait (cells_sent >= HOLD_AT);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Wait for the plan and the pipeline to empty, then report
  initial begin
    wait (rst_n);
    while (cell_plan.size() != 0 || in_valid || cfg_valid || pending_slopes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_PAD) @(posedge clk);
    if (mismatches == 0 && pending_slopes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
